[rtl/tpro_pkg.sv]
// Shared types and constants for the triangle point / rectangle overlap pipeline.
// No dependencies.
`timescale 1ns / 1ps

package tpro_pkg;

  localparam int NVERT   = 3;
  localparam int NCORNER = 4;

  localparam logic MODE_POINT = 1'b0;
  localparam logic MODE_RECT  = 1'b1;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [16:0] corner_t;
  typedef logic signed [17:0] diff_t;
  typedef logic signed [35:0] prod_t;
  typedef logic        [35:0] mag_t;
  typedef logic        [37:0] sum_t;
  typedef logic        [14:0] extent_t;

  typedef struct packed {
    logic                 mode;
    coord_t [NVERT-1:0]   vx;
    coord_t [NVERT-1:0]   vy;
    coord_t               qx;
    coord_t               qy;
    extent_t              w;
    extent_t              h;
  } query_t;

  typedef struct packed {
    logic                             mode;
    logic                             vin;
    diff_t [NCORNER-1:0][NVERT-1:0]   dx;
    diff_t [NCORNER-1:0][NVERT-1:0]   dy;
    diff_t [3:0]                      wd;
  } geom_t;

  typedef struct packed {
    logic                             mode;
    logic                             vin;
    mag_t  [NCORNER-1:0][NVERT-1:0]   s;
    mag_t                             whole;
  } area_t;

endpackage

[rtl/triangle_point_rect_overlap.sv]
// Triangle point / rectangle overlap test, five-stage pipeline.
// Throughput: one transaction per cycle whenever the pipeline advances.
// The whole pipeline advances when the output register is empty or being taken.
// Reset (rst_n low, synchronous) clears all stage valid bits; no result is pending after it.
// Depends on tpro_pkg, tpro_setup, tpro_cross, tpro_resolve.
`timescale 1ns / 1ps

module triangle_point_rect_overlap import tpro_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tri_ax, tri_ay, tri_bx, tri_by, tri_cx, tri_cy, query_x, query_y,
  // rect_width, rect_height, 2 zero bits
  input  logic [159:0] in_tdata,
  // mode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit, 7 zero bits
  output logic [7:0]   out_tdata
);

  logic   en;
  query_t q;
  logic   geom_valid, area_valid, res_valid, res_hit;
  geom_t  geom;
  area_t  area;

  assign en        = !res_valid || out_tready;
  assign in_tready = en;

  assign q.mode  = in_tuser;
  assign q.vx[0] = in_tdata[15:0];
  assign q.vy[0] = in_tdata[31:16];
  assign q.vx[1] = in_tdata[47:32];
  assign q.vy[1] = in_tdata[63:48];
  assign q.vx[2] = in_tdata[79:64];
  assign q.vy[2] = in_tdata[95:80];
  assign q.qx    = in_tdata[111:96];
  assign q.qy    = in_tdata[127:112];
  assign q.w     = in_tdata[142:128];
  assign q.h     = in_tdata[157:143];

  tpro_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_q      (q),
    .out_valid (geom_valid),
    .out_geom  (geom)
  );

  tpro_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (geom_valid),
    .in_geom   (geom),
    .out_valid (area_valid),
    .out_area  (area)
  );

  tpro_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (area_valid),
    .in_area   (area),
    .out_valid (res_valid),
    .out_hit   (res_hit)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {7'b0000000, res_hit};

endmodule

[rtl/tpro_setup.sv]
// Stages 1-2: rectangle corners, then vertex-minus-corner differences and the
// strict vertex-in-rectangle test. Depends on tpro_pkg.
`timescale 1ns / 1ps

module tpro_setup import tpro_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  input  query_t in_q,
  output logic   out_valid,
  output geom_t  out_geom
);

  logic                 a_valid_r;
  logic                 a_mode_r;
  coord_t [NVERT-1:0]   a_vx_r, a_vy_r;
  corner_t              a_ql_r, a_qt_r, a_rr_r, a_rb_r;
  corner_t              a_rr_nxt, a_rb_nxt;

  logic                 b_valid_r;
  geom_t                b_geom_r, b_geom_nxt;

  assign a_rr_nxt = {in_q.qx[15], in_q.qx} + {2'b00, in_q.w};
  assign a_rb_nxt = {in_q.qy[15], in_q.qy} + {2'b00, in_q.h};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode_r <= in_q.mode;
      a_vx_r   <= in_q.vx;
      a_vy_r   <= in_q.vy;
      a_ql_r   <= {in_q.qx[15], in_q.qx};
      a_qt_r   <= {in_q.qy[15], in_q.qy};
      a_rr_r   <= a_rr_nxt;
      a_rb_r   <= a_rb_nxt;
    end
  end

  always_comb begin
    corner_t px [NCORNER];
    corner_t py [NCORNER];
    corner_t vxe, vye;
    px[0] = a_ql_r; py[0] = a_qt_r;
    px[1] = a_rr_r; py[1] = a_qt_r;
    px[2] = a_ql_r; py[2] = a_rb_r;
    px[3] = a_rr_r; py[3] = a_rb_r;
    b_geom_nxt      = '0;
    b_geom_nxt.mode = a_mode_r;
    for (int i = 0; i < NVERT; i++) begin
      vxe = {a_vx_r[i][15], a_vx_r[i]};
      vye = {a_vy_r[i][15], a_vy_r[i]};
      if ((vxe > a_ql_r) && (vxe < a_rr_r) && (vye > a_qt_r) && (vye < a_rb_r)) begin
        b_geom_nxt.vin = 1'b1;
      end
      for (int k = 0; k < NCORNER; k++) begin
        b_geom_nxt.dx[k][i] = diff_t'({vxe[16], vxe} - {px[k][16], px[k]});
        b_geom_nxt.dy[k][i] = diff_t'({vye[16], vye} - {py[k][16], py[k]});
      end
    end
    b_geom_nxt.wd[0] = diff_t'({{2{a_vx_r[1][15]}}, a_vx_r[1]} - {{2{a_vx_r[0][15]}}, a_vx_r[0]});
    b_geom_nxt.wd[1] = diff_t'({{2{a_vy_r[2][15]}}, a_vy_r[2]} - {{2{a_vy_r[0][15]}}, a_vy_r[0]});
    b_geom_nxt.wd[2] = diff_t'({{2{a_vx_r[2][15]}}, a_vx_r[2]} - {{2{a_vx_r[0][15]}}, a_vx_r[0]});
    b_geom_nxt.wd[3] = diff_t'({{2{a_vy_r[1][15]}}, a_vy_r[1]} - {{2{a_vy_r[0][15]}}, a_vy_r[0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_geom_r <= b_geom_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_geom  = b_geom_r;

endmodule

[rtl/tpro_cross.sv]
// Stages 3-4: 18x18 products for every sub-triangle and the whole triangle,
// then cross differences and magnitudes. Depends on tpro_pkg.
`timescale 1ns / 1ps

module tpro_cross import tpro_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  geom_t in_geom,
  output logic  out_valid,
  output area_t out_area
);

  logic                             c_valid_r;
  logic                             c_mode_r, c_vin_r;
  prod_t [NCORNER-1:0][NVERT-1:0]   c_p1_r, c_p2_r, c_p1_nxt, c_p2_nxt;
  prod_t                            c_wp1_r, c_wp2_r, c_wp1_nxt, c_wp2_nxt;

  logic                             d_valid_r;
  area_t                            d_area_r, d_area_nxt;

  function automatic mag_t abs_diff(prod_t a, prod_t b);
    logic signed [36:0] df;
    logic signed [36:0] ng;
    df = {a[35], a} - {b[35], b};
    ng = -df;
    return df[36] ? ng[35:0] : df[35:0];
  endfunction

  always_comb begin
    int n;
    for (int k = 0; k < NCORNER; k++) begin
      for (int j = 0; j < NVERT; j++) begin
        n = (j + 1) % NVERT;
        c_p1_nxt[k][j] = prod_t'($signed(in_geom.dx[k][j])) * prod_t'($signed(in_geom.dy[k][n]));
        c_p2_nxt[k][j] = prod_t'($signed(in_geom.dx[k][n])) * prod_t'($signed(in_geom.dy[k][j]));
      end
    end
    c_wp1_nxt = prod_t'($signed(in_geom.wd[0])) * prod_t'($signed(in_geom.wd[1]));
    c_wp2_nxt = prod_t'($signed(in_geom.wd[2])) * prod_t'($signed(in_geom.wd[3]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= in_valid;
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mode_r <= in_geom.mode;
      c_vin_r  <= in_geom.vin;
      c_p1_r   <= c_p1_nxt;
      c_p2_r   <= c_p2_nxt;
      c_wp1_r  <= c_wp1_nxt;
      c_wp2_r  <= c_wp2_nxt;
      d_area_r <= d_area_nxt;
    end
  end

  always_comb begin
    d_area_nxt.mode = c_mode_r;
    d_area_nxt.vin  = c_vin_r;
    for (int k = 0; k < NCORNER; k++) begin
      for (int j = 0; j < NVERT; j++) begin
        d_area_nxt.s[k][j] = abs_diff(c_p1_r[k][j], c_p2_r[k][j]);
      end
    end
    d_area_nxt.whole = abs_diff(c_wp1_r, c_wp2_r);
  end

  assign out_valid = d_valid_r;
  assign out_area  = d_area_r;

endmodule

[rtl/tpro_resolve.sv]
// Stage 5: sub-area sums against the whole area and the final hit select;
// holds the output register. Depends on tpro_pkg.
`timescale 1ns / 1ps

module tpro_resolve import tpro_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  area_t in_area,
  output logic  out_valid,
  output logic  out_hit
);

  logic e_valid_r;
  logic e_hit_r, e_hit_nxt;

  always_comb begin
    logic [NCORNER-1:0] pt;
    sum_t               tot;
    for (int k = 0; k < NCORNER; k++) begin
      tot   = {2'b00, in_area.s[k][0]} + {2'b00, in_area.s[k][1]} + {2'b00, in_area.s[k][2]};
      pt[k] = (tot == {2'b00, in_area.whole});
    end
    case (in_area.mode)
      MODE_POINT: e_hit_nxt = pt[0];
      MODE_RECT:  e_hit_nxt = in_area.vin | (|pt);
      default:    e_hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_hit_r <= e_hit_nxt;
    end
  end

  assign out_valid = e_valid_r;
  assign out_hit   = e_hit_r;

endmodule

[tb/sv/tb.sv]
// Self-checking bench for triangle_point_rect_overlap: directed table, then random queries.
// Fixed table rows carry their own expected hit; all others are checked against an exact integer hit predictor.
// Depends on tpro_pkg and the triangle_point_rect_overlap RTL.
`timescale 1ns / 1ps

module tb import tpro_pkg::*; ();

  localparam int N_ITEMS = 1400;

  typedef struct {
    query_t q;
    bit     fixed;
    bit     hit;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;

  bit       expected_hits[$];
  dir_row_t dir_rows[$];
  int       send_idle_pct;
  int       recv_idle_pct;
  int       n_fail;
  int       n_checked;
  int       n_hits;
  int       n_point;
  int       n_rect;

  triangle_point_rect_overlap DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // doubled sub-areas sum to the doubled triangle area: inside or on an edge
  function automatic bit point_in_triangle(query_t q, longint px, longint py);
    longint ax, ay, bx, by, cx, cy, whole, s1, s2, s3;
    ax = longint'($signed(q.vx[0]));
    ay = longint'($signed(q.vy[0]));
    bx = longint'($signed(q.vx[1]));
    by = longint'($signed(q.vy[1]));
    cx = longint'($signed(q.vx[2]));
    cy = longint'($signed(q.vy[2]));
    whole = abs_l((bx - ax) * (cy - ay) - (cx - ax) * (by - ay));
    s1 = abs_l((ax - px) * (by - py) - (bx - px) * (ay - py));
    s2 = abs_l((bx - px) * (cy - py) - (cx - px) * (by - py));
    s3 = abs_l((cx - px) * (ay - py) - (ax - px) * (cy - py));
    return (s1 + s2 + s3) == whole;
  endfunction

  function automatic bit predict_hit(query_t q);
    longint qx, qy, rr, rb, vx, vy;
    bit     hit;
    qx = longint'($signed(q.qx));
    qy = longint'($signed(q.qy));
    if (q.mode == MODE_POINT) return point_in_triangle(q, qx, qy);
    rr = qx + longint'(q.w);
    rb = qy + longint'(q.h);
    hit = 1'b0;
    for (int i = 0; i < NVERT; i++) begin
      vx = longint'($signed(q.vx[i]));
      vy = longint'($signed(q.vy[i]));
      if (vx > qx && vx < rr && vy > qy && vy < rb) hit = 1'b1;
    end
    hit |= point_in_triangle(q, qx, qy) | point_in_triangle(q, rr, qy);
    hit |= point_in_triangle(q, qx, rb) | point_in_triangle(q, rr, rb);
    return hit;
  endfunction

  function automatic coord_t to_coord(int v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic query_t make_query(bit m, int ax, int ay, int bx, int by, int cx,
                                        int cy, int qx, int qy, int w, int h);
    query_t q;
    q.mode  = m;
    q.vx[0] = to_coord(ax);
    q.vy[0] = to_coord(ay);
    q.vx[1] = to_coord(bx);
    q.vy[1] = to_coord(by);
    q.vx[2] = to_coord(cx);
    q.vy[2] = to_coord(cy);
    q.qx    = to_coord(qx);
    q.qy    = to_coord(qy);
    q.w     = extent_t'(w);
    q.h     = extent_t'(h);
    return q;
  endfunction

  function automatic void add_row(bit m, int ax, int ay, int bx, int by, int cx, int cy,
                                  int qx, int qy, int w, int h, bit fixed, bit hit);
    dir_row_t r;
    r.q     = make_query(m, ax, ay, bx, by, cx, cy, qx, qy, w, h);
    r.fixed = fixed;
    r.hit   = hit;
    dir_rows.push_back(r);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int pick_extreme();
    int vals[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    return vals[$urandom_range(6)];
  endfunction

  function automatic query_t random_query();
    bit m;
    int sel, r, bx0, by0, dx, dy, k;
    int c[8];
    int w, h;
    m   = $urandom_range(1);
    sel = $urandom_range(9);
    w   = $urandom_range(32767);
    h   = $urandom_range(32767);
    if (sel <= 2) begin
      foreach (c[i]) c[i] = rand_coord();
    end else if (sel <= 6) begin
      // clustered shapes so hits and misses are both common
      r   = 1 << $urandom_range(10);
      bx0 = rand_coord();
      by0 = rand_coord();
      for (int i = 0; i < 4; i++) begin
        c[2*i]   = bx0 + int'($urandom_range(2*r)) - r;
        c[2*i+1] = by0 + int'($urandom_range(2*r)) - r;
      end
      w = $urandom_range(2*r);
      h = $urandom_range(2*r);
      if (m) begin
        c[6] = c[6] - w / 2;
        c[7] = c[7] - h / 2;
      end
    end else if (sel == 7) begin
      // query on a vertex or near an edge midpoint
      r = 1 << $urandom_range(14);
      for (int i = 0; i < 6; i++) c[i] = int'($urandom_range(2*r)) - r;
      k = $urandom_range(2);
      if ($urandom_range(1)) begin
        c[6] = c[2*k];
        c[7] = c[2*k+1];
      end else begin
        c[6] = (c[2*k] + c[(2*k+2)%6]) >>> 1;
        c[7] = (c[2*k+1] + c[(2*k+3)%6]) >>> 1;
      end
      w = $urandom_range(3);
      h = $urandom_range(3);
    end else if (sel == 8) begin
      // collinear vertices
      dx = int'($urandom_range(200)) - 100;
      dy = int'($urandom_range(200)) - 100;
      c[0] = int'($urandom_range(20000)) - 10000;
      c[1] = int'($urandom_range(20000)) - 10000;
      k = int'($urandom_range(20)) - 10;
      c[2] = c[0] + dx;
      c[3] = c[1] + dy;
      c[4] = c[0] + k * dx;
      c[5] = c[1] + k * dy;
      k = int'($urandom_range(20)) - 10;
      c[6] = c[0] + k * dx + int'($urandom_range(1));
      c[7] = c[1] + k * dy;
      w = $urandom_range(4);
      h = $urandom_range(4);
    end else begin
      foreach (c[i]) c[i] = pick_extreme();
      w = $urandom_range(1) ? 32767 : $urandom_range(1);
      h = $urandom_range(1) ? 32767 : $urandom_range(1);
    end
    return make_query(m, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], w, h);
  endfunction

  function automatic logic [159:0] pack_query(query_t q);
    return {2'b00, q.h, q.w, q.qy, q.qx, q.vy[2], q.vx[2], q.vy[1], q.vx[1],
            q.vy[0], q.vx[0]};
  endfunction

  function automatic void set_phase(int idx);
    if (idx < N_ITEMS / 3) begin
      send_idle_pct = 37;
      recv_idle_pct = 48;
    end else if (idx < 2 * N_ITEMS / 3) begin
      send_idle_pct = 48;
      recv_idle_pct = 37;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endfunction

  task automatic send_query(query_t q, bit hit);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_query(q);
    in_tuser  <= q.mode;
    do @(posedge clk); while (!in_tready);
    expected_hits.push_back(hit);
    if (q.mode == MODE_POINT) n_point++;
    else n_rect++;
  endtask

  // result side: check accepted transactions, then randomize tready
  always @(posedge clk) begin
    bit want;
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result, hit=%0b", $time, out_tdata[0]);
        n_fail++;
      end else begin
        want = expected_hits.pop_front();
        if (out_tdata[0] !== want) begin
          $display("%0t: hit mismatch, expected %0b actual %0b", $time, want, out_tdata[0]);
          n_fail++;
        end
        if (want) n_hits++;
      end
    end
    out_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  initial begin
    query_t q;
    int     idx;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    rst_n      = 1'b0;
    n_fail     = 0;
    n_checked  = 0;
    n_hits     = 0;
    n_point    = 0;
    n_rect     = 0;
    set_phase(0);

    // point mode: vertex, interior, edge, outside, far corner
    add_row(MODE_POINT, 0, 0, 100, 0, 0, 100, 0, 0, 0, 0, 1, 1);
    add_row(MODE_POINT, 0, 0, 100, 0, 0, 100, 10, 10, 32767, 32767, 1, 1);
    add_row(MODE_POINT, 0, 0, 100, 0, 0, 100, 50, 50, 0, 0, 1, 1);
    add_row(MODE_POINT, 0, 0, 100, 0, 0, 100, 51, 50, 0, 0, 1, 0);
    add_row(MODE_POINT, 0, 0, 100, 0, 0, 100, -32768, -32768, 0, 0, 1, 0);
    // full-range triangle, hypotenuse x + y = -1
    add_row(MODE_POINT, -32768, -32768, 32767, -32768, -32768, 32767, -1, 0, 0, 0, 1, 1);
    add_row(MODE_POINT, -32768, -32768, 32767, -32768, -32768, 32767, 0, 0, 0, 0, 1, 0);
    add_row(MODE_POINT, 32767, 32767, -32768, 32767, 32767, -32768, 32767, 32767, 0, 0, 1, 1);
    // collinear and single-point triangles
    add_row(MODE_POINT, 0, 0, 10, 10, 20, 20, 5, 5, 0, 0, 1, 1);
    add_row(MODE_POINT, 0, 0, 10, 10, 20, 20, 5, 6, 0, 0, 1, 0);
    add_row(MODE_POINT, 0, 0, 10, 10, 20, 20, 30, 30, 0, 0, 0, 0);
    add_row(MODE_POINT, 7, 7, 7, 7, 7, 7, 7, 7, 0, 0, 1, 1);
    add_row(MODE_POINT, 7, 7, 7, 7, 7, 7, 8, 7, 0, 0, 0, 0);
    // rectangle mode
    add_row(MODE_RECT, 0, 0, 1000, 0, 0, 1000, 990, -5, 20, 10, 1, 1);
    add_row(MODE_RECT, 0, 0, 1000, 0, 0, 1000, 2000, 2000, 10, 10, 1, 0);
    add_row(MODE_RECT, 0, 0, 1000, 0, 0, 1000, 1000, 0, 10, 10, 1, 1);
    add_row(MODE_RECT, 0, 0, 100, 0, 0, 100, 10, 10, 0, 0, 1, 1);
    add_row(MODE_RECT, 0, 0, 100, 0, 0, 100, -10, -10, 0, 0, 1, 0);
    add_row(MODE_RECT, -100, -100, -50, -100, -100, -50, -32768, -32768, 32767, 32767, 1, 1);
    add_row(MODE_RECT, 32767, 32767, 32767, -32768, -32768, 32767, 32767, 32767, 32767, 32767,
            1, 1);
    // edges cross but nothing is contained: not reported; then a single-point triangle inside
    add_row(MODE_RECT, 0, 0, 100, 0, 50, 100, -50, 40, 200, 10, 1, 0);
    add_row(MODE_RECT, 0, 0, 100, 0, 50, 100, 40, -50, 0, 32767, 0, 0);
    add_row(MODE_RECT, -32768, 32767, 32767, -32768, 0, 0, -32768, -32768, 32767, 0, 0, 0);
    add_row(MODE_RECT, 5, 5, 5, 5, 5, 5, 0, 0, 10, 10, 1, 1);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    idx = 0;
    foreach (dir_rows[i]) begin
      set_phase(idx);
      send_query(dir_rows[i].q, dir_rows[i].fixed ? dir_rows[i].hit : predict_hit(dir_rows[i].q));
      idx++;
    end
    while (idx < N_ITEMS) begin
      set_phase(idx);
      q = random_query();
      send_query(q, predict_hit(q));
      idx++;
    end
    in_tvalid <= 1'b0;

    while (expected_hits.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Ran %0d point and %0d rectangle queries under three stall patterns.",
             n_point, n_rect);
    $display("Checked %0d results, %0d of them hits; %0d errors.", n_checked, n_hits, n_fail);
    if (n_fail == 0) begin
      $display("** triangle_point_rect_overlap: PASSED **");
    end else begin
      $display("** triangle_point_rect_overlap: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d results outstanding", $time, expected_hits.size());
    $display("** triangle_point_rect_overlap: FAILED **");
    $finish;
  end

endmodule
